@@ src/swd_pkg.sv @@
package swd_pkg;

    // angle units: 1/2^AFB degree at the ports, 1/2^QZ degree inside the CORDIC
    localparam int AFB      = 7;
    localparam int QZ       = 20;
    localparam int USH      = QZ - AFB;
    localparam int ENC_BITS = 13;            // encoder counts per turn = 2^ENC_BITS

    localparam int DEG360 = 360 << AFB;
    localparam int DEG180 = 180 << AFB;
    localparam int DEG95  = 95 << AFB;

    localparam int CW     = 36;              // CORDIC x/y width
    localparam int ZW     = 32;              // CORDIC angle width
    localparam int AW     = 18;              // signed work width for unit angles
    localparam int VW     = 34;              // wheel speed magnitude, Q16
    localparam int DNW    = VW + 16;         // divider numerator width
    localparam int QB     = 16;              // divider quotient bits
    localparam int CSTEPS = 20;

    // config register indexes
    localparam logic [2:0] REG_SLEW     = 3'd0;
    localparam logic [2:0] REG_LIMIT    = 3'd1;
    localparam logic [2:0] REG_DEADBAND = 3'd2;
    localparam logic [2:0] REG_CTR_FL   = 3'd3;
    localparam logic [2:0] REG_CTR_FR   = 3'd4;
    localparam logic [2:0] REG_CTR_BL   = 3'd5;
    localparam logic [2:0] REG_CTR_BR   = 3'd6;

    localparam logic signed [ZW-1:0] Q90  = ZW'(90 << QZ);
    localparam logic signed [ZW-1:0] Q180 = ZW'(180 << QZ);
    localparam logic [29:0]          INVK = 30'd652032874;   // 1/K in Q30

    typedef struct packed {
        logic                 start;
        logic                 vec;       // 1: vectoring (atan2), 0: rotation
        logic [14:0]          mag;
        logic signed [AW-1:0] ang;
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
    } t_cordic_req;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic_rsp;

    typedef struct packed {
        logic           start;
        logic [DNW-1:0] num;
        logic [VW-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [QB-1:0] quo;
    } t_div_rsp;

    // arctan(2^-k) in 1/2^20 degree
    function automatic logic signed [ZW-1:0] atan_q(input logic [4:0] k);
        logic signed [ZW-1:0] r;
        case (k)
            5'd0:  r = 32'sd47185920;
            5'd1:  r = 32'sd27855475;
            5'd2:  r = 32'sd14718068;
            5'd3:  r = 32'sd7471121;
            5'd4:  r = 32'sd3750058;
            5'd5:  r = 32'sd1876857;
            5'd6:  r = 32'sd938658;
            5'd7:  r = 32'sd469357;
            5'd8:  r = 32'sd234682;
            5'd9:  r = 32'sd117342;
            5'd10: r = 32'sd58671;
            5'd11: r = 32'sd29335;
            5'd12: r = 32'sd14668;
            5'd13: r = 32'sd7334;
            5'd14: r = 32'sd3667;
            5'd15: r = 32'sd1833;
            5'd16: r = 32'sd917;
            5'd17: r = 32'sd458;
            5'd18: r = 32'sd229;
            5'd19: r = 32'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

    // wrap a unit angle to [-180, 180); input within one turn of that range
    function automatic logic signed [AW-1:0] wrap_half(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        if (a >= AW'(DEG180))
            r = a - AW'(DEG360);
        else if (a < -AW'(DEG180))
            r = a + AW'(DEG360);
        else
            r = a;
        return r;
    endfunction

    // CORDIC angle to unit angle, round half up
    function automatic logic signed [AW-1:0] q_to_unit(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] t;
        t = (z + ZW'(1 << (USH - 1))) >>> USH;
        return t[AW-1:0];
    endfunction

    // spin angle per wheel: none, turning left, turning right
    function automatic logic signed [AW-1:0] spin_angle(input logic [1:0] pat,
                                                        input logic [1:0] w);
        logic signed [AW-1:0] r;
        logic signed [AW-1:0] d45;
        logic signed [AW-1:0] d135;
        d45  = AW'(45 << AFB);
        d135 = AW'(135 << AFB);
        r    = '0;
        if (pat == 2'd1) begin
            case (w)
                2'd0:    r = d45;
                2'd1:    r = d135;
                2'd2:    r = -d45;
                default: r = -d135;
            endcase
        end else if (pat == 2'd2) begin
            case (w)
                2'd0:    r = -d135;
                2'd1:    r = -d45;
                2'd2:    r = d135;
                default: r = d45;
            endcase
        end
        return r;
    endfunction

endpackage

@@ src/swd_cordic.sv @@
// Shared CORDIC: rotation (mag at ang) or vectoring (angle of vx, vy),
// one micro-rotation per cycle, done pulses with results after the last step.
module swd_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swd_pkg::t_cordic_req i_req,
    output swd_pkg::t_cordic_rsp o_rsp
);

    logic signed [swd_pkg::CW-1:0] r_x, r_y;
    logic signed [swd_pkg::ZW-1:0] r_z;
    logic                          r_neg, r_zero, r_vec, r_busy, r_done;
    logic [4:0]                    r_k;

    logic signed [swd_pkg::AW-1:0] ang_w;
    logic signed [swd_pkg::ZW-1:0] zq;
    logic [44:0]                   prod;
    logic signed [swd_pkg::CW-1:0] xs, ys;
    logic signed [swd_pkg::ZW-1:0] at;
    logic                          dir_pos;

    // load-side: wrap, scale to CORDIC units, gain-compensated magnitude
    always_comb begin
        ang_w = swd_pkg::wrap_half(i_req.ang);
        zq    = swd_pkg::ZW'(ang_w) <<< swd_pkg::USH;
        prod  = 45'(i_req.mag) * 45'(swd_pkg::INVK);
    end

    // step-side
    always_comb begin
        xs      = r_x >>> r_k;
        ys      = r_y >>> r_k;
        at      = swd_pkg::atan_q(r_k);
        dir_pos = r_vec ? (r_y <= 0) : (r_z >= 0);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 5'd1;
                if (r_k == 5'(swd_pkg::CSTEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_vec <= i_req.vec;
            if (!i_req.vec) begin
                r_x    <= swd_pkg::CW'(prod[44:14]);
                r_y    <= '0;
                r_zero <= 1'b0;
                if (zq > swd_pkg::Q90) begin
                    r_z   <= zq - swd_pkg::Q180;
                    r_neg <= 1'b1;
                end else if (zq < -swd_pkg::Q90) begin
                    r_z   <= zq + swd_pkg::Q180;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= zq;
                    r_neg <= 1'b0;
                end
            end else begin
                r_neg  <= 1'b0;
                r_zero <= (i_req.vx == '0) && (i_req.vy == '0);
                if (i_req.vx < 0) begin
                    r_x <= -i_req.vx;
                    r_y <= -i_req.vy;
                    r_z <= (i_req.vy >= 0) ? swd_pkg::Q180 : -swd_pkg::Q180;
                end else begin
                    r_x <= i_req.vx;
                    r_y <= i_req.vy;
                    r_z <= '0;
                end
            end
        end else if (r_busy) begin
            if (dir_pos) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_neg ? -r_x : r_x;
    assign o_rsp.y    = r_neg ? -r_y : r_y;
    assign o_rsp.z    = r_zero ? '0 : r_z;

endmodule

@@ src/swd_div.sv @@
// Restoring divider, one quotient bit per cycle; needs num < den * 2^QB.
module swd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swd_pkg::t_div_req i_req,
    output swd_pkg::t_div_rsp o_rsp
);

    logic [swd_pkg::VW-1:0] r_rem, r_den;
    logic [swd_pkg::QB-1:0] r_lo, r_q;
    logic [3:0]             r_k;
    logic                   r_busy, r_done;

    logic [swd_pkg::VW:0]   trial;
    logic                   fits;

    always_comb begin
        trial = {r_rem, r_lo[swd_pkg::QB-1]};
        fits  = trial >= {1'b0, r_den};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 4'd1;
                if (r_k == 4'(swd_pkg::QB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[swd_pkg::DNW-1:swd_pkg::QB];
            r_lo  <= i_req.num[swd_pkg::QB-1:0];
            r_den <= i_req.den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? swd_pkg::VW'(trial - {1'b0, r_den}) : trial[swd_pkg::VW-1:0];
            r_lo  <= r_lo << 1;
            r_q   <= {r_q[swd_pkg::QB-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

@@ src/swerve_drive_kinematics.sv @@
// Four-wheel swerve inverse kinematics, one control tick per input item. An
// item with the brake flag yields no result; any other item yields four
// results (front left, front right, back left, back right, the last flagged
// by tlast). One CORDIC unit does 12 to 17 passes (heading when the speed
// exceeds the deadband, then per wheel one rotation, an optional atan2 and
// two more rotations), and a 16-step divider runs per wheel when the speeds
// must be scaled down. After a non-brake item is accepted, the input is not
// ready until the fourth result is taken.
// Configuration is to be written by the user while idle; the block does not
// enforce it. Center values are wrapped to one turn.
module swerve_drive_kinematics (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_data,
    // input item stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // move_cmd, strafe_cmd, turn_cmd, enc_fl, enc_fr, enc_bl, enc_br
    input  logic [103:0] s_axis_tdata,
    // brake_active
    input  logic         s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // wheel_index, steer_target, drive_target
    output logic [39:0]  m_axis_tdata,
    // reversed
    output logic         m_axis_tuser,
    // last_wheel
    output logic         m_axis_tlast
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HEAD  = 4'd1;
    localparam logic [3:0] S_HEADW = 4'd2;
    localparam logic [3:0] S_R1    = 4'd3;
    localparam logic [3:0] S_R1W   = 4'd4;
    localparam logic [3:0] S_V     = 4'd5;
    localparam logic [3:0] S_VW    = 4'd6;
    localparam logic [3:0] S_R2    = 4'd7;
    localparam logic [3:0] S_R2W   = 4'd8;
    localparam logic [3:0] S_R3    = 4'd9;
    localparam logic [3:0] S_R3W   = 4'd10;
    localparam logic [3:0] S_SPD   = 4'd11;
    localparam logic [3:0] S_DIVW  = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    localparam int CW  = swd_pkg::CW;
    localparam int AW  = swd_pkg::AW;
    localparam int VW  = swd_pkg::VW;
    localparam int EB  = swd_pkg::ENC_BITS;
    localparam logic signed [CW-1:0] ONE_Q16 = CW'(65536);

    function automatic logic signed [15:0] slew(input logic signed [14:0] cmd,
                                                input logic signed [15:0] prev,
                                                input logic [9:0] st);
        logic signed [17:0] d;
        logic signed [17:0] sx;
        logic signed [15:0] r;
        d  = 18'(cmd) - 18'(prev);
        sx = $signed({8'b0, st});
        if (d > sx)
            r = prev + $signed({6'b0, st});
        else if (d < -sx)
            r = prev - $signed({6'b0, st});
        else
            r = 16'(cmd);
        return r;
    endfunction

    // config
    logic [9:0]  r_slew;
    logic [14:0] r_limit;
    logic [7:0]  r_deadband;
    logic [15:0] r_center [4];

    // tick state
    logic [3:0]         r_state, n_state;
    logic [1:0]         r_w;
    logic signed [15:0] r_prev_move, r_prev_strafe, r_prev_turn;
    logic signed [15:0] r_held;
    logic [1:0]         r_spin;
    logic signed [15:0] r_wh [4];

    // per-tick payload
    logic [EB-1:0]        r_enc [4];
    logic [14:0]          r_xy, r_ts;
    logic signed [CW-1:0] r_px, r_py;
    logic [VW-1:0]        r_c1, r_maxv;
    logic [VW-1:0]        r_v [4];
    logic [15:0]          r_spd;
    logic [1:0]           r_o_idx;
    logic [15:0]          r_o_steer;
    logic [15:0]          r_o_drive;
    logic                 r_o_rev;

    swd_pkg::t_cordic_req c_req;
    swd_pkg::t_cordic_rsp c_rsp;
    swd_pkg::t_div_req    d_req;
    swd_pkg::t_div_rsp    d_rsp;

    // input decode and slew
    logic               in_brake, accept;
    logic signed [15:0] m_new, s_new, t_new;
    logic [15:0]        m_abs, s_abs, t_abs, xy_raw;
    logic [14:0]        xy_new;

    always_comb begin
        in_brake = s_axis_tuser;
        accept   = s_axis_tvalid && s_axis_tready;
        if (in_brake) begin
            m_new = '0;
            s_new = '0;
            t_new = '0;
        end else begin
            m_new = slew($signed(s_axis_tdata[14:0]), r_prev_move, r_slew);
            s_new = slew($signed(s_axis_tdata[29:15]), r_prev_strafe, r_slew);
            t_new = slew($signed(s_axis_tdata[44:30]), r_prev_turn, r_slew);
        end
        m_abs  = m_new[15] ? 16'(-m_new) : 16'(m_new);
        s_abs  = s_new[15] ? 16'(-s_new) : 16'(s_new);
        t_abs  = t_new[15] ? 16'(-t_new) : 16'(t_new);
        xy_raw = (m_abs > s_abs) ? m_abs : s_abs;
        xy_new = (xy_raw > {1'b0, r_limit}) ? r_limit : xy_raw[14:0];
    end

    // wheel working values
    logic signed [AW-1:0] sa, held_x, wh_x;
    logic                 head_upd, need_vec, scale;
    logic [VW-1:0]        cx_abs, v_sum, v_cur;
    logic [VW:0]          spd_round;

    always_comb begin
        sa        = swd_pkg::spin_angle(r_spin, r_w);
        held_x    = AW'(r_held);
        wh_x      = AW'(r_wh[r_w]);
        head_upd  = r_xy > 15'(r_deadband);
        need_vec  = (r_px > ONE_Q16) || (r_px < -ONE_Q16) ||
                    (r_py > ONE_Q16) || (r_py < -ONE_Q16);
        cx_abs    = c_rsp.x[CW-1] ? VW'(-c_rsp.x) : VW'(c_rsp.x);
        v_sum     = r_c1 + cx_abs;
        v_cur     = r_v[r_w];
        scale     = r_maxv > VW'({r_limit, 16'b0});
        spd_round = {1'b0, v_cur} + (VW+1)'(32768);
    end

    // CORDIC request
    always_comb begin
        c_req       = '0;
        c_req.start = (r_state == S_HEAD && head_upd) || (r_state == S_R1) ||
                      (r_state == S_V && need_vec) || (r_state == S_R2) ||
                      (r_state == S_R3);
        c_req.vec   = (r_state == S_HEAD) || (r_state == S_V);
        c_req.mag   = (r_state == S_R3) ? r_xy : r_ts;
        case (r_state)
            S_R1:    c_req.ang = sa - held_x;
            S_R2:    c_req.ang = sa - wh_x;
            S_R3:    c_req.ang = wh_x - held_x;
            default: c_req.ang = '0;
        endcase
        if (r_state == S_HEAD) begin
            c_req.vx = {{(CW-32){r_prev_move[15]}}, r_prev_move, 16'b0};
            c_req.vy = {{(CW-32){r_prev_strafe[15]}}, r_prev_strafe, 16'b0};
        end else begin
            c_req.vx = r_py;
            c_req.vy = r_px;
        end
    end

    // divider request: round(v * limit / maxv)
    always_comb begin
        d_req.start = (r_state == S_SPD) && scale;
        d_req.num   = swd_pkg::DNW'(v_cur) * swd_pkg::DNW'(r_limit) +
                      swd_pkg::DNW'(r_maxv >> 1);
        d_req.den   = r_maxv;
    end

    swd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_req),
        .o_rsp   (c_rsp)
    );

    swd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (d_req),
        .o_rsp   (d_rsp)
    );

    // result forming
    logic [EB+15:0]       enc_prod;
    logic signed [AW-1:0] encd, err, tgt_raw, tgt;
    logic                 rev;

    always_comb begin
        enc_prod = (EB+16)'(r_enc[r_w]) * (EB+16)'(swd_pkg::DEG360);
        encd     = $signed({{(AW-16){1'b0}}, enc_prod[EB +: 16]});
        err      = swd_pkg::wrap_half(wh_x + $signed({2'b0, r_center[r_w]}) - encd);
        rev      = (err > AW'(swd_pkg::DEG95)) || (err < -AW'(swd_pkg::DEG95));
        tgt_raw  = $signed({2'b0, r_center[r_w]}) + wh_x +
                   (rev ? AW'(swd_pkg::DEG180) : AW'(0));
        if (tgt_raw < 0)
            tgt = tgt_raw + AW'(swd_pkg::DEG360);
        else if (tgt_raw >= AW'(swd_pkg::DEG360))
            tgt = tgt_raw - AW'(swd_pkg::DEG360);
        else
            tgt = tgt_raw;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_axis_tvalid && !in_brake) n_state = S_HEAD;
            S_HEAD:  n_state = head_upd ? S_HEADW : S_R1;
            S_HEADW: if (c_rsp.done) n_state = S_R1;
            S_R1:    n_state = S_R1W;
            S_R1W:   if (c_rsp.done) n_state = S_V;
            S_V:     n_state = need_vec ? S_VW : S_R2;
            S_VW:    if (c_rsp.done) n_state = S_R2;
            S_R2:    n_state = S_R2W;
            S_R2W:   if (c_rsp.done) n_state = S_R3;
            S_R3:    n_state = S_R3W;
            S_R3W:   if (c_rsp.done) n_state = (r_w == 2'd3) ? S_SPD : S_R1;
            S_SPD:   n_state = scale ? S_DIVW : S_FIN;
            S_DIVW:  if (d_rsp.done) n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = (r_w == 2'd3) ? S_IDLE : S_SPD;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_w           <= '0;
            r_slew        <= 10'd20;
            r_limit       <= 15'd8000;
            r_deadband    <= 8'd5;
            r_center      <= '{default: '0};
            r_prev_move   <= '0;
            r_prev_strafe <= '0;
            r_prev_turn   <= '0;
            r_held        <= '0;
            r_spin        <= '0;
            r_wh          <= '{default: '0};
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    swd_pkg::REG_SLEW:     r_slew     <= i_cfg_data[9:0];
                    swd_pkg::REG_LIMIT:    r_limit    <= i_cfg_data[14:0];
                    swd_pkg::REG_DEADBAND: r_deadband <= i_cfg_data[7:0];
                    swd_pkg::REG_CTR_FL, swd_pkg::REG_CTR_FR,
                    swd_pkg::REG_CTR_BL, swd_pkg::REG_CTR_BR:
                        r_center[2'(i_cfg_addr - swd_pkg::REG_CTR_FL)] <=
                            (i_cfg_data >= 16'(swd_pkg::DEG360)) ?
                            i_cfg_data - 16'(swd_pkg::DEG360) : i_cfg_data;
                    default: ;
                endcase
            end

            if (accept) begin
                r_prev_move   <= m_new;
                r_prev_strafe <= s_new;
                r_prev_turn   <= t_new;
                if (t_new > 0)
                    r_spin <= 2'd1;
                else if (t_new < 0)
                    r_spin <= 2'd2;
            end

            if (r_state == S_HEAD)
                r_w <= '0;
            if (r_state == S_HEADW && c_rsp.done)
                r_held <= 16'(swd_pkg::wrap_half(swd_pkg::q_to_unit(c_rsp.z)));
            if (r_state == S_VW && c_rsp.done)
                r_wh[r_w] <= 16'(swd_pkg::wrap_half(held_x + swd_pkg::q_to_unit(c_rsp.z)));
            if (r_state == S_R3W && c_rsp.done)
                r_w <= r_w + 2'd1;
            if (r_state == S_OUT && m_axis_tready)
                r_w <= r_w + 2'd1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_enc[0] <= s_axis_tdata[57:45];
            r_enc[1] <= s_axis_tdata[70:58];
            r_enc[2] <= s_axis_tdata[83:71];
            r_enc[3] <= s_axis_tdata[96:84];
            r_xy     <= xy_new;
            r_ts     <= t_abs[14:0];
            r_maxv   <= '0;
        end
        if (r_state == S_R1W && c_rsp.done) begin
            r_px <= c_rsp.y;
            r_py <= c_rsp.x + {{(CW-31){1'b0}}, r_xy, 16'b0};
        end
        if (r_state == S_R2W && c_rsp.done)
            r_c1 <= cx_abs;
        if (r_state == S_R3W && c_rsp.done) begin
            r_v[r_w] <= v_sum;
            if (v_sum > r_maxv)
                r_maxv <= v_sum;
        end
        if (r_state == S_SPD && !scale)
            r_spd <= spd_round[31:16];
        if (r_state == S_DIVW && d_rsp.done)
            r_spd <= d_rsp.quo;
        if (r_state == S_FIN) begin
            r_o_idx   <= r_w;
            r_o_steer <= tgt[15:0];
            r_o_drive <= (rev ^ r_w[0]) ? 16'(-r_spd) : r_spd;
            r_o_rev   <= rev;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {6'b0, r_o_drive, r_o_steer, r_o_idx};
    assign m_axis_tuser  = r_o_rev;
    assign m_axis_tlast  = (r_o_idx == 2'd3);

endmodule

@@ src/swd_checker.sv @@
module swd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // one tick at a time: no new item while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // tlast marks exactly the back right wheel
    a_last_wheel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'd3)))
        else $error("tlast does not match wheel index");

    // steering target within one turn, drive never the most negative code
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:2] < 16'd46080) &&
                          (m_axis_tdata[33:18] != 16'h8000))
        else $error("result out of range");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // reset clears the output
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind swerve_drive_kinematics swd_checker u_swd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/tb_swerve_drive_kinematics.sv @@
module tb_swerve_drive_kinematics;

    localparam int      CYCLE_LIMIT = 1_000_000;
    localparam int      SETTLE      = 600;       // longer than the slowest tick
    localparam longint  FULL_TURN   = 360 << swd_pkg::AFB;
    localparam longint  Q_ONE       = 65536;
    localparam longint  INV_GAIN    = 652032874;

    typedef struct {
        logic [1:0]  wheel;
        logic [15:0] steer;
        logic [15:0] drive;
        logic        rev;
        logic        last;
    } t_wheel_cmd;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    swerve_drive_kinematics i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of config and state
    int unsigned slew_step = 20, speed_limit = 8000, heading_deadband = 5;
    int unsigned center[4] = '{0, 0, 0, 0};
    int          kept_move = 0, kept_strafe = 0, kept_turn = 0;
    longint      heading_hold = 0;
    int          spin_mode = 0;
    longint      wheel_dir[4] = '{0, 0, 0, 0};

    t_wheel_cmd  pending_wheels[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          rx_hold = 0;        // long receiver hold-off, in cycles
    int          rx_gap = 0;
    bit          no_idle = 0;

    // ---------------- kinematics predictor ----------------
    function automatic longint wrap_turn(longint a);
        longint m;
        m = a % FULL_TURN;
        if (m < 0) m += FULL_TURN;
        return m;
    endfunction

    function automatic longint wrap_pm(longint a);
        longint m;
        m = wrap_turn(a);
        if (m >= FULL_TURN / 2) m -= FULL_TURN;
        return m;
    endfunction

    function automatic longint to_units(longint z);
        return (z + (longint'(1) <<< (swd_pkg::USH - 1))) >>> swd_pkg::USH;
    endfunction

    function automatic longint arctan_step(int k);
        longint tab[20] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                            938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
                            3667, 1833, 917, 458, 229, 115};
        return tab[k];
    endfunction

    // mag*cos(ang), mag*sin(ang) in Q16
    function automatic void rotate_vec(longint mag, longint ang,
                                       output longint c, output longint sn);
        longint z, x, y, nx;
        bit     neg;
        z = wrap_pm(ang) * (longint'(1) <<< swd_pkg::USH);
        x = (mag * INV_GAIN) >>> 14;
        y = 0;
        neg = 0;
        if (z > (longint'(90) <<< swd_pkg::QZ)) begin
            z -= longint'(180) <<< swd_pkg::QZ; neg = 1;
        end else if (z < -(longint'(90) <<< swd_pkg::QZ)) begin
            z += longint'(180) <<< swd_pkg::QZ; neg = 1;
        end
        for (int i = 0; i < swd_pkg::CSTEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_step(i);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_step(i);
            end
            x = nx;
        end
        c  = neg ? -x : x;
        sn = neg ? -y : y;
    endfunction

    // angle of (xv, yv) in 1/2^20 degree
    function automatic longint vec_angle(longint yv, longint xv);
        longint z, nx;
        z = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            z = (yv >= 0) ? (longint'(180) <<< swd_pkg::QZ)
                          : -(longint'(180) <<< swd_pkg::QZ);
            xv = -xv; yv = -yv;
        end
        for (int i = 0; i < swd_pkg::CSTEPS; i++) begin
            if (yv > 0) begin
                nx = xv + (yv >>> i); yv = yv - (xv >>> i); z += arctan_step(i);
            end else begin
                nx = xv - (yv >>> i); yv = yv + (xv >>> i); z -= arctan_step(i);
            end
            xv = nx;
        end
        return z;
    endfunction

    function automatic longint spin_units(int mode, int w);
        int d45 [4] = '{45, 135, -45, -135};
        int dneg[4] = '{-135, -45, 135, 45};
        if (mode == 1) return longint'(d45[w]) <<< swd_pkg::AFB;
        if (mode == 2) return longint'(dneg[w]) <<< swd_pkg::AFB;
        return 0;
    endfunction

    function automatic int slew_to(int cmd, int prev);
        int st;
        st = slew_step;
        if (cmd - prev > st) return prev + st;
        if (cmd - prev < -st) return prev - st;
        return cmd;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // one control tick: update state, queue the four wheel commands unless braking
    function automatic void predict_tick(logic signed [14:0] mv, logic signed [14:0] sf,
                                         logic signed [14:0] tn, logic brake,
                                         logic [12:0] enc[4]);
        int     m, s, t;
        longint xy, ts, c, sn, d, x, y, c1, c2, maxv, spd, encd, err, tgt, drv, sa;
        longint v[4];
        bit     rev, right;
        t_wheel_cmd w;
        m = 0; s = 0; t = 0; maxv = 0;
        if (!brake) begin
            m = slew_to(int'(mv), kept_move);
            s = slew_to(int'(sf), kept_strafe);
            t = slew_to(int'(tn), kept_turn);
        end
        kept_move = m; kept_strafe = s; kept_turn = t;
        xy = mag(m) > mag(s) ? mag(m) : mag(s);
        if (xy > speed_limit) xy = speed_limit;
        ts = mag(t);
        if (xy > heading_deadband)
            heading_hold = wrap_pm(to_units(vec_angle(longint'(s) * Q_ONE,
                                                      longint'(m) * Q_ONE)));
        if (t > 0) spin_mode = 1;
        else if (t < 0) spin_mode = 2;
        if (brake) return;
        for (int i = 0; i < 4; i++) begin
            sa = spin_units(spin_mode, i);
            rotate_vec(ts, sa - heading_hold, c, sn);
            x = sn;
            y = c + xy * Q_ONE;
            if (mag(x) > Q_ONE || mag(y) > Q_ONE)
                wheel_dir[i] = wrap_pm(heading_hold + to_units(vec_angle(x, y)));
            rotate_vec(ts, sa - wheel_dir[i], c1, d);
            rotate_vec(xy, wheel_dir[i] - heading_hold, c2, d);
            v[i] = mag(c1) + mag(c2);
            if (v[i] > maxv) maxv = v[i];
        end
        for (int i = 0; i < 4; i++) begin
            right = (i == 1 || i == 3);
            if (maxv > longint'(speed_limit) * Q_ONE)
                spd = (v[i] * speed_limit + maxv / 2) / maxv;
            else
                spd = (v[i] + Q_ONE / 2) >>> 16;
            encd = (longint'(enc[i]) * FULL_TURN) / (longint'(1) <<< swd_pkg::ENC_BITS);
            err  = wrap_pm(wheel_dir[i] + center[i] - encd);
            rev  = mag(err) > (longint'(95) <<< swd_pkg::AFB);
            tgt  = wrap_turn(center[i] + wheel_dir[i] + (rev ? FULL_TURN / 2 : 0));
            drv  = (rev != right) ? -spd : spd;
            w.wheel = i[1:0];
            w.steer = tgt[15:0];
            w.drive = drv[15:0];
            w.rev   = rev;
            w.last  = (i == 3);
            pending_wheels.push_back(w);
        end
    endfunction

    // ---------------- drivers ----------------
    task automatic send_tick(logic [14:0] mv, logic [14:0] sf, logic [14:0] tn,
                             logic brake, logic [12:0] enc[4]);
        int gap;
        @(negedge i_clk);
        s_axis_tdata  = {7'b0, enc[3], enc[2], enc[1], enc[0], tn, sf, mv};
        s_axis_tuser  = brake;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_tick(mv, sf, tn, brake, enc);
        gap = no_idle ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(8, 60)
                                                          : $urandom_range(0, 2));
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_enc(int mv, int sf, int tn, logic brake, int e0, int e1,
                            int e2, int e3);
        logic [12:0] enc[4];
        enc = '{e0[12:0], e1[12:0], e2[12:0], e3[12:0]};
        send_tick(mv[14:0], sf[14:0], tn[14:0], brake, enc);
    endtask

    // wait until the block is idle with nothing outstanding
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_wheels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val[15:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            swd_pkg::REG_SLEW:     slew_step = val & 32'h3FF;
            swd_pkg::REG_LIMIT:    speed_limit = val & 32'h7FFF;
            swd_pkg::REG_DEADBAND: heading_deadband = val & 32'hFF;
            default:               center[idx - swd_pkg::REG_CTR_FL] = val & 32'hFFFF;
        endcase
    endtask

    task automatic write_centers(int unsigned a, int unsigned b, int unsigned c,
                                 int unsigned d);
        write_reg(swd_pkg::REG_CTR_FL, a);
        write_reg(swd_pkg::REG_CTR_FR, b);
        write_reg(swd_pkg::REG_CTR_BL, c);
        write_reg(swd_pkg::REG_CTR_BR, d);
    endtask

    function automatic int rand_cmd();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return $urandom_range(0, 6) - 3;
            2:       return $urandom_range(0, 1) ? 16383 : -16384;
            default: return int'($urandom_range(0, 32767)) - 16384;
        endcase
    endfunction

    task automatic send_random();
        send_enc(rand_cmd(), rand_cmd(), rand_cmd(), $urandom_range(0, 9) == 0,
                 $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 8191), $urandom_range(0, 8191));
    endtask

    // ---------------- result side ----------------
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end else if (rx_gap > 0) begin
            m_axis_tready = 1'b0;
            rx_gap--;
        end else begin
            m_axis_tready = 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0)
                rx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 50)
                                                    : $urandom_range(1, 3);
        end
    end

    // compare each wheel command with the oldest prediction
    always @(posedge i_clk) begin
        t_wheel_cmd w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_wheels.size() == 0) begin
                $error("unexpected wheel result %h", m_axis_tdata);
                fail_count++;
            end else begin
                w = pending_wheels.pop_front();
                if (m_axis_tdata[1:0] !== w.wheel) begin
                    $error("wheel_index exp %0d got %0d", w.wheel, m_axis_tdata[1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[17:2] !== w.steer) begin
                    $error("steer_target exp %0d got %0d", w.steer, m_axis_tdata[17:2]);
                    fail_count++;
                end
                if (m_axis_tdata[33:18] !== w.drive) begin
                    $error("drive_target exp %0d got %0d", $signed(w.drive),
                           $signed(m_axis_tdata[33:18]));
                    fail_count++;
                end
                if (m_axis_tuser !== w.rev) begin
                    $error("reversed exp %0d got %0d", w.rev, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tlast !== w.last) begin
                    $error("last_wheel exp %0d got %0d", w.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- tests ----------------
    // reset values: slow slew, heading hold at low speed, spin hold, braking
    task automatic test_reset_defaults();
        send_enc(16383, 0, 0, 0, 0, 0, 0, 0);
        send_enc(16383, 0, 16383, 0, 8191, 8191, 8191, 8191);
        send_enc(0, 0, 0, 0, 4096, 2048, 6144, 100);
        send_enc(3, -2, 0, 0, 0, 0, 0, 0);
        send_enc(0, 0, -16384, 1, 0, 0, 0, 0);
        send_enc(0, 0, 0, 0, 0, 0, 0, 0);
        settle();
    endtask

    // full slew: field extremes, both spin directions, flips, speed scaling
    task automatic test_extremes();
        write_reg(swd_pkg::REG_SLEW, 1023);
        write_centers(46079, 0, 23040, 11520);
        send_enc(-16384, -16384, -16384, 0, 8191, 0, 4096, 2048);
        send_enc(16383, 16383, 16383, 0, 0, 8191, 0, 8191);
        send_enc(1023, -1023, 0, 0, 4096, 4096, 4096, 4096);
        send_enc(0, 1023, -1023, 0, 1000, 3000, 5000, 7000);
        send_enc(0, 0, 1023, 0, 0, 0, 0, 0);
        send_enc(0, 0, 0, 0, 8191, 8191, 8191, 8191);
        send_enc(1, 1, 0, 0, 0, 0, 0, 0);
        send_enc(-1023, 0, 0, 1, 0, 0, 0, 0);
        send_enc(-1023, 0, 0, 0, 2160, 6000, 200, 4000);
        settle();
    endtask

    // corner settings of every register
    task automatic test_config_corners();
        write_reg(swd_pkg::REG_SLEW, 0);
        write_reg(swd_pkg::REG_LIMIT, 0);
        write_reg(swd_pkg::REG_DEADBAND, 255);
        send_enc(5000, 5000, 5000, 0, 10, 20, 30, 40);
        settle();
        write_reg(swd_pkg::REG_SLEW, 1023);
        write_reg(swd_pkg::REG_LIMIT, 32767);
        write_reg(swd_pkg::REG_DEADBAND, 0);
        write_centers(0, 46079, 0, 46079);
        send_enc(16383, -16384, 16383, 0, 8191, 0, 8191, 0);
        send_enc(1, 0, 0, 0, 0, 0, 0, 0);
        send_enc(-16384, 16383, -16384, 0, 4095, 4096, 4097, 1);
        settle();
    endtask

    task automatic test_random(int n, bit random_cfg);
        if (random_cfg) begin
            write_reg(swd_pkg::REG_SLEW, $urandom_range(0, 1023));
            write_reg(swd_pkg::REG_LIMIT, $urandom_range(0, 32767));
            write_reg(swd_pkg::REG_DEADBAND, $urandom_range(0, 255));
            write_centers($urandom_range(0, 46079), $urandom_range(0, 46079),
                          $urandom_range(0, 46079), $urandom_range(0, 46079));
        end
        repeat (n) send_random();
        settle();
    endtask

    // receiver stalls long while ticks keep coming
    task automatic test_backpressure();
        @(posedge i_clk);
        rx_hold = 1500;
        repeat (6) send_random();
        settle();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_extremes();
        test_config_corners();
        write_reg(swd_pkg::REG_SLEW, 20);
        write_reg(swd_pkg::REG_LIMIT, 8000);
        write_reg(swd_pkg::REG_DEADBAND, 5);
        write_centers(0, 0, 0, 0);
        test_random(50, 0);
        no_idle = 1;
        test_random(30, 1);
        no_idle = 0;
        test_backpressure();
        test_random(60, 1);
        test_random(60, 1);
        write_reg(swd_pkg::REG_SLEW, 1023);
        write_reg(swd_pkg::REG_LIMIT, 32767);
        test_random(40, 0);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
